// File: hw/rtl/cbse_pkg.sv
// Shared types and constants for the cubic Bezier spline evaluator.
// No dependencies; every other file in hw/rtl but cbse_ram uses it by scoped name.
package cbse_pkg;

    localparam int COORD_W    = 32;
    localparam int INDEX_W    = 6;
    localparam int COUNT_W    = 7;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    // Cycles through the three blend levels (multiply stage plus add stage each)
    localparam int BLEND_LAT = 6;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd2;
    localparam logic [COUNT_W-1:0] COUNT_MIN   = 7'd2;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_POINT_COUNT = 1'd0;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } vec3_t;

    // One table row: the anchor together with one of its handles
    typedef struct packed {
        vec3_t anchor;
        vec3_t handle;
    } pair_t;

endpackage

// File: hw/rtl/cbse_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cbse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/cbse_lerp.sv
// Two-stage fixed-point lerp: a + floor(((b - a) * tt + half) / one).
// Depends on cbse_pkg for the coordinate width.
module cbse_lerp #(
    parameter int TT_W = 17
) (
    input  logic                                 clk,
    input  logic signed [cbse_pkg::COORD_W-1:0]  a,
    input  logic signed [cbse_pkg::COORD_W-1:0]  b,
    input  logic        [TT_W-1:0]               tt,
    output logic signed [cbse_pkg::COORD_W+1:0]  sum
);

    localparam int DIFF_W = cbse_pkg::COORD_W + 1;
    localparam int PROD_W = DIFF_W + TT_W + 1;
    localparam int FRAC   = TT_W - 1;
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC - 1);

    logic signed [DIFF_W-1:0]            diff;
    logic signed [TT_W:0]                tt_s;
    logic signed [PROD_W-1:0]            prod_next;
    logic signed [PROD_W-1:0]            prod_reg;
    logic signed [cbse_pkg::COORD_W-1:0] a_reg;
    logic signed [PROD_W-1:0]            rounded;
    logic signed [PROD_W-1:0]            shifted;
    logic signed [DIFF_W-1:0]            step;
    logic signed [cbse_pkg::COORD_W+1:0] sum_next;
    logic signed [cbse_pkg::COORD_W+1:0] sum_reg;

    // Multiply stage
    assign diff      = {b[cbse_pkg::COORD_W-1], b} - {a[cbse_pkg::COORD_W-1], a};
    assign tt_s      = {1'b0, tt};
    assign prod_next = diff * tt_s;

    // Round, floor-shift and add back the start point
    assign rounded  = prod_reg + HALF;
    assign shifted  = rounded >>> FRAC;
    assign step     = shifted[DIFF_W-1:0];
    assign sum_next = {{2{a_reg[cbse_pkg::COORD_W-1]}}, a_reg}
                    + {step[DIFF_W-1], step};

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        a_reg    <= a;
        sum_reg  <= sum_next;
    end

    assign sum = sum_reg;

endmodule

// File: hw/rtl/cbse_blend.sv
// One axis of the cubic blend: three levels of de Casteljau lerps, then saturation.
// Depends on cbse_pkg and cbse_lerp.
module cbse_blend #(
    parameter int TT_W = 17
) (
    input  logic                                clk,
    input  logic signed [cbse_pkg::COORD_W-1:0] p0,
    input  logic signed [cbse_pkg::COORD_W-1:0] p1,
    input  logic signed [cbse_pkg::COORD_W-1:0] p2,
    input  logic signed [cbse_pkg::COORD_W-1:0] p3,
    input  logic        [TT_W-1:0]              tt,
    output logic signed [cbse_pkg::COORD_W-1:0] result
);

    localparam int W = cbse_pkg::COORD_W;

    logic [TT_W-1:0] tt_dly_reg [4];

    logic signed [W+1:0] a_sum, b_sum, c_sum, d_sum, e_sum, r_sum;

    always_ff @(posedge clk)
    begin
        tt_dly_reg[0] <= tt;
        tt_dly_reg[1] <= tt_dly_reg[0];
        tt_dly_reg[2] <= tt_dly_reg[1];
        tt_dly_reg[3] <= tt_dly_reg[2];
    end

    // Level one
    cbse_lerp #(.TT_W(TT_W)) u_lerp_a (.clk(clk), .a(p0), .b(p1), .tt(tt), .sum(a_sum));
    cbse_lerp #(.TT_W(TT_W)) u_lerp_b (.clk(clk), .a(p1), .b(p2), .tt(tt), .sum(b_sum));
    cbse_lerp #(.TT_W(TT_W)) u_lerp_c (.clk(clk), .a(p2), .b(p3), .tt(tt), .sum(c_sum));

    // Level two: a lerp stays between its inputs, so the low word is exact
    cbse_lerp #(.TT_W(TT_W)) u_lerp_d (
        .clk(clk), .a(a_sum[W-1:0]), .b(b_sum[W-1:0]), .tt(tt_dly_reg[1]), .sum(d_sum)
    );
    cbse_lerp #(.TT_W(TT_W)) u_lerp_e (
        .clk(clk), .a(b_sum[W-1:0]), .b(c_sum[W-1:0]), .tt(tt_dly_reg[1]), .sum(e_sum)
    );

    // Level three
    cbse_lerp #(.TT_W(TT_W)) u_lerp_r (
        .clk(clk), .a(d_sum[W-1:0]), .b(e_sum[W-1:0]), .tt(tt_dly_reg[3]), .sum(r_sum)
    );

    always_comb
    begin
        if ((r_sum[W+1:W-1] == 3'b000) || (r_sum[W+1:W-1] == 3'b111))
        begin
            result = r_sum[W-1:0];
        end
        else if (r_sum[W+1])
        begin
            result = cbse_pkg::COORD_MIN;
        end
        else
        begin
            result = cbse_pkg::COORD_MAX;
        end
    end

endmodule

// File: hw/rtl/cubic_bezier_spline_evaluator_unit.sv
// Top level of the piecewise cubic Bezier spline evaluator.
// Depends on cbse_pkg, cbse_ram, cbse_lerp and cbse_blend.

// The block takes one transfer on every clock: busy never rises, so start may
// be held high continuously. A load transfer (action = 0) writes one spline
// point and produces nothing. An evaluate transfer (action = 1) produces one
// result, shown for a single cycle with done high. The receiver cannot stall
// the output, so sample curve_x/y/z whenever done is high. The pipeline runs
// segment selection, the table read, then per blend level a multiply stage
// and a round-and-add stage over three levels, then the output register. The
// point table is not cleared after reset; evaluate only segments whose points
// have all been loaded. Write point_count only while no evaluate is in
// flight. Loads and evaluates take effect in the order they are transferred.
module cubic_bezier_spline_evaluator_unit #(
    parameter int MAX_POINTS  = 64,
    parameter int T_FRAC_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,

    // Command side
    input  logic                                    start,
    output logic                                    busy,
    input  logic                                    action,
    input  logic        [cbse_pkg::INDEX_W-1:0]     point_index,
    input  logic signed [cbse_pkg::COORD_W-1:0]     anchor_x_in,
    input  logic signed [cbse_pkg::COORD_W-1:0]     anchor_y_in,
    input  logic signed [cbse_pkg::COORD_W-1:0]     anchor_z_in,
    input  logic signed [cbse_pkg::COORD_W-1:0]     left_x_in,
    input  logic signed [cbse_pkg::COORD_W-1:0]     left_y_in,
    input  logic signed [cbse_pkg::COORD_W-1:0]     left_z_in,
    input  logic signed [cbse_pkg::COORD_W-1:0]     right_x_in,
    input  logic signed [cbse_pkg::COORD_W-1:0]     right_y_in,
    input  logic signed [cbse_pkg::COORD_W-1:0]     right_z_in,
    input  logic        [T_FRAC_BITS:0]             param_t,

    // Result side
    output logic                                    done,
    output logic signed [cbse_pkg::COORD_W-1:0]     curve_x,
    output logic signed [cbse_pkg::COORD_W-1:0]     curve_y,
    output logic signed [cbse_pkg::COORD_W-1:0]     curve_z,

    // Configuration port
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic        [cbse_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic        [cbse_pkg::APB_DATA_W-1:0]  pwdata,
    output logic        [cbse_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                    pready
);

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int TT_W   = T_FRAC_BITS + 1;
    localparam int LEN_W  = TT_W + ADDR_W;
    localparam logic [TT_W-1:0] ONE_T = TT_W'(1) << T_FRAC_BITS;
    localparam int LAT = cbse_pkg::BLEND_LAT;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [cbse_pkg::COUNT_W-1:0]   point_count_reg;
    logic [cbse_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[cbse_pkg::APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= cbse_pkg::COUNT_RESET;
        end
        else if (cfg_write && (reg_idx == cbse_pkg::REG_POINT_COUNT))
        begin
            point_count_reg <= pwdata[cbse_pkg::COUNT_W-1:0];
        end
    end

    always_comb
    begin
        case (reg_idx)
            cbse_pkg::REG_POINT_COUNT:
                prdata = cbse_pkg::APB_DATA_W'(point_count_reg);
            default:
                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 1: segment selection, load decode
    // ------------------------------------------------------------------
    logic                accept;
    logic [31:0]         count_eff;
    logic [ADDR_W-1:0]   segs;
    logic [TT_W-1:0]     t_clamp;
    logic [LEN_W-1:0]    len;
    logic [ADDR_W:0]     seg_idx;
    logic [ADDR_W-1:0]   i0_next;
    logic [TT_W-1:0]     tt_next;
    logic                load_ok;

    // Never back-pressure: the pipeline has no stall point
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Clamp the point count into the supported range
    always_comb
    begin
        if (point_count_reg < cbse_pkg::COUNT_MIN)
        begin
            count_eff = 32'(cbse_pkg::COUNT_MIN);
        end
        else if (32'(point_count_reg) > 32'(MAX_POINTS))
        begin
            count_eff = 32'(MAX_POINTS);
        end
        else
        begin
            count_eff = 32'(point_count_reg);
        end
    end

    assign segs    = ADDR_W'(count_eff - 32'd1);
    assign t_clamp = (param_t > ONE_T) ? ONE_T : param_t;
    assign len     = LEN_W'(t_clamp) * LEN_W'(segs);
    assign seg_idx = len[LEN_W-1:T_FRAC_BITS];

    // End of curve: hold the last segment with the fraction at one
    always_comb
    begin
        if (seg_idx >= {1'b0, segs})
        begin
            i0_next = segs - ADDR_W'(1);
            tt_next = ONE_T;
        end
        else
        begin
            i0_next = seg_idx[ADDR_W-1:0];
            tt_next = {1'b0, len[T_FRAC_BITS-1:0]};
        end
    end

    // Drop loads that fall outside the table
    assign load_ok = 32'(point_index) < 32'(MAX_POINTS);

    logic                s1_load_reg;
    logic                s1_eval_reg;
    logic [ADDR_W-1:0]   s1_waddr_reg;
    cbse_pkg::pair_t     s1_wdata_a_reg;
    cbse_pkg::pair_t     s1_wdata_b_reg;
    logic [ADDR_W-1:0]   s1_i0_reg;
    logic [ADDR_W-1:0]   s1_i1_reg;
    logic [TT_W-1:0]     s1_tt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_load_reg <= 1'b0;
            s1_eval_reg <= 1'b0;
        end
        else
        begin
            s1_load_reg <= accept && (action == cbse_pkg::ACT_LOAD) && load_ok;
            s1_eval_reg <= accept && (action == cbse_pkg::ACT_EVAL);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_waddr_reg          <= ADDR_W'(point_index);
        s1_wdata_a_reg.anchor <= '{x: anchor_x_in, y: anchor_y_in, z: anchor_z_in};
        s1_wdata_a_reg.handle <= '{x: right_x_in, y: right_y_in, z: right_z_in};
        s1_wdata_b_reg.anchor <= '{x: anchor_x_in, y: anchor_y_in, z: anchor_z_in};
        s1_wdata_b_reg.handle <= '{x: left_x_in, y: left_y_in, z: left_z_in};
        s1_i0_reg             <= i0_next;
        s1_i1_reg             <= i0_next + ADDR_W'(1);
        s1_tt_reg             <= tt_next;
    end

    // ------------------------------------------------------------------
    // Stage 2: table read. Writes and reads both issue from stage 1, so the
    // transfer order is kept. Table A holds anchor and right handle (read at
    // the segment start), table B anchor and left handle (read at its end).
    // ------------------------------------------------------------------
    cbse_pkg::pair_t rd_a;
    cbse_pkg::pair_t rd_b;

    cbse_ram #(
        .WIDTH ($bits(cbse_pkg::pair_t)),
        .DEPTH (MAX_POINTS)
    ) u_ram_a (
        .clk   (clk),
        .we    (s1_load_reg),
        .waddr (s1_waddr_reg),
        .wdata (s1_wdata_a_reg),
        .raddr (s1_i0_reg),
        .rdata (rd_a)
    );

    cbse_ram #(
        .WIDTH ($bits(cbse_pkg::pair_t)),
        .DEPTH (MAX_POINTS)
    ) u_ram_b (
        .clk   (clk),
        .we    (s1_load_reg),
        .waddr (s1_waddr_reg),
        .wdata (s1_wdata_b_reg),
        .raddr (s1_i1_reg),
        .rdata (rd_b)
    );

    logic            s2_eval_reg;
    logic [TT_W-1:0] s2_tt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_eval_reg <= 1'b0;
        end
        else
        begin
            s2_eval_reg <= s1_eval_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_tt_reg <= s1_tt_reg;
    end

    // ------------------------------------------------------------------
    // Blend stages, one unit per axis
    // ------------------------------------------------------------------
    logic signed [cbse_pkg::COORD_W-1:0] blend_x, blend_y, blend_z;

    cbse_blend #(.TT_W(TT_W)) u_blend_x (
        .clk    (clk),
        .p0     (rd_a.anchor.x),
        .p1     (rd_a.handle.x),
        .p2     (rd_b.handle.x),
        .p3     (rd_b.anchor.x),
        .tt     (s2_tt_reg),
        .result (blend_x)
    );

    cbse_blend #(.TT_W(TT_W)) u_blend_y (
        .clk    (clk),
        .p0     (rd_a.anchor.y),
        .p1     (rd_a.handle.y),
        .p2     (rd_b.handle.y),
        .p3     (rd_b.anchor.y),
        .tt     (s2_tt_reg),
        .result (blend_y)
    );

    cbse_blend #(.TT_W(TT_W)) u_blend_z (
        .clk    (clk),
        .p0     (rd_a.anchor.z),
        .p1     (rd_a.handle.z),
        .p2     (rd_b.handle.z),
        .p3     (rd_b.anchor.z),
        .tt     (s2_tt_reg),
        .result (blend_z)
    );

    // Advance the valid bit alongside the blend stages
    logic [LAT-1:0] vld_reg;
    logic           done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[LAT-2:0], s2_eval_reg};
            done_reg <= vld_reg[LAT-1];
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic signed [cbse_pkg::COORD_W-1:0] curve_x_reg, curve_y_reg, curve_z_reg;

    always_ff @(posedge clk)
    begin
        curve_x_reg <= blend_x;
        curve_y_reg <= blend_y;
        curve_z_reg <= blend_z;
    end

    assign done    = done_reg;
    assign curve_x = curve_x_reg;
    assign curve_y = curve_y_reg;
    assign curve_z = curve_z_reg;

endmodule

// File: test/testbench.sv
// Self-checking bench for cubic_bezier_spline_evaluator_unit: loads spline points,
// evaluates the curve and checks every result against a predictor kept in this file
// or a value given in the directed table. Depends on cbse_pkg and the evaluator's RTL only.
module testbench;

    localparam int    NPTS         = 64;
    localparam int    TBITS        = 16;
    localparam longint ONE_T       = 64'sd1 << TBITS;
    // Result delay after the accepting edge; SETTLE leaves some slack
    localparam int    PIPE_LAT     = 8;
    localparam int    SETTLE       = PIPE_LAT + 4;
    localparam int    QUIET_LIMIT  = 2000;
    localparam int    ITEMS_PER_PHASE = 55;
    localparam int    NUM_PHASES   = 10;

    localparam logic [cbse_pkg::APB_ADDR_W-1:0] ADDR_POINT_COUNT =
        {cbse_pkg::REG_POINT_COUNT, 2'b00};

    typedef struct packed {
        cbse_pkg::vec3_t anchor;
        cbse_pkg::vec3_t left;
        cbse_pkg::vec3_t right;
    } spline_point_t;

    // One command on the input side; typed marks a result read straight off the table
    typedef struct packed {
        logic                           action;
        logic [cbse_pkg::INDEX_W-1:0]   idx;
        spline_point_t                  pt;
        logic [TBITS:0]                 t;
        logic                           typed;
        cbse_pkg::vec3_t                result;
    } command_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 start = 1'b0;
    logic                                 busy;
    logic                                 action = cbse_pkg::ACT_LOAD;
    logic [cbse_pkg::INDEX_W-1:0]         point_index = '0;
    logic signed [cbse_pkg::COORD_W-1:0]  anchor_x_in = '0;
    logic signed [cbse_pkg::COORD_W-1:0]  anchor_y_in = '0;
    logic signed [cbse_pkg::COORD_W-1:0]  anchor_z_in = '0;
    logic signed [cbse_pkg::COORD_W-1:0]  left_x_in = '0;
    logic signed [cbse_pkg::COORD_W-1:0]  left_y_in = '0;
    logic signed [cbse_pkg::COORD_W-1:0]  left_z_in = '0;
    logic signed [cbse_pkg::COORD_W-1:0]  right_x_in = '0;
    logic signed [cbse_pkg::COORD_W-1:0]  right_y_in = '0;
    logic signed [cbse_pkg::COORD_W-1:0]  right_z_in = '0;
    logic [TBITS:0]                       param_t = '0;
    logic                                 done;
    logic signed [cbse_pkg::COORD_W-1:0]  curve_x;
    logic signed [cbse_pkg::COORD_W-1:0]  curve_y;
    logic signed [cbse_pkg::COORD_W-1:0]  curve_z;
    logic                                 psel = 1'b0;
    logic                                 penable = 1'b0;
    logic                                 pwrite = 1'b0;
    logic [cbse_pkg::APB_ADDR_W-1:0]      paddr = '0;
    logic [cbse_pkg::APB_DATA_W-1:0]      pwdata = '0;
    logic [cbse_pkg::APB_DATA_W-1:0]      prdata;
    logic                                 pready;

    // Predictor state: its own copy of the point table and of point_count
    spline_point_t                point_table [NPTS];
    logic [NPTS-1:0]              loaded_mask = '0;
    logic [cbse_pkg::COUNT_W-1:0] count_reg = cbse_pkg::COUNT_RESET;

    cbse_pkg::vec3_t pending_curves [$];
    command_t        directed [$];
    int              mismatches = 0;
    int              loads_done = 0;
    int              evals_done = 0;
    int              quiet_cycles = 0;

    int                           idle_pct_by_phase [3] = '{0, 50, 37};
    logic [cbse_pkg::COUNT_W-1:0] phase_counts [NUM_PHASES] =
        '{7'd2, 7'd64, 7'd0, 7'd127, 7'd5, 7'd1, 7'd33, 7'd65, 7'd17, 7'd3};

    string axis_name [3] = '{"z", "y", "x"};

    cubic_bezier_spline_evaluator_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .point_index (point_index),
        .anchor_x_in (anchor_x_in),
        .anchor_y_in (anchor_y_in),
        .anchor_z_in (anchor_z_in),
        .left_x_in   (left_x_in),
        .left_y_in   (left_y_in),
        .left_z_in   (left_z_in),
        .right_x_in  (right_x_in),
        .right_y_in  (right_y_in),
        .right_z_in  (right_z_in),
        .param_t     (param_t),
        .done        (done),
        .curve_x     (curve_x),
        .curve_y     (curve_y),
        .curve_z     (curve_z),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic cbse_pkg::vec3_t xyz(input logic signed [cbse_pkg::COORD_W-1:0] x,
                                            input logic signed [cbse_pkg::COORD_W-1:0] y,
                                            input logic signed [cbse_pkg::COORD_W-1:0] z);
        cbse_pkg::vec3_t v;
        v.x = x;
        v.y = y;
        v.z = z;
        return v;
    endfunction

    function automatic command_t load_cmd(input int idx, input cbse_pkg::vec3_t a,
                                          input cbse_pkg::vec3_t l,
                                          input cbse_pkg::vec3_t r);
        command_t c;
        c = '0;
        c.action    = cbse_pkg::ACT_LOAD;
        c.idx       = cbse_pkg::INDEX_W'(idx);
        c.pt.anchor = a;
        c.pt.left   = l;
        c.pt.right  = r;
        return c;
    endfunction

    function automatic command_t eval_cmd(input int t, input logic typed,
                                          input cbse_pkg::vec3_t r);
        command_t c;
        c = '0;
        c.action = cbse_pkg::ACT_EVAL;
        c.t      = (TBITS+1)'(t);
        c.typed  = typed;
        c.result = r;
        return c;
    endfunction

    // Append one row to the directed table
    task automatic add_row(input command_t c);
        directed.insert(directed.size(), c);
    endtask

    // Out-of-range counts fold to the nearest legal one
    function automatic int effective_count();
        int c;
        c = int'(count_reg);
        if (c < 2)
            return 2;
        if (c > NPTS)
            return NPTS;
        return c;
    endfunction

    // Move a toward b by tt/ONE, rounding half up; >>> floors the signed sum
    function automatic longint mix_toward(input longint a, input longint b, input longint tt);
        return a + (((b - a) * tt + ONE_T / 2) >>> TBITS);
    endfunction

    function automatic logic signed [cbse_pkg::COORD_W-1:0] blend_axis(
        input longint p0, input longint p1, input longint p2, input longint p3,
        input longint tt);
        longint a, b, c, d, e, r;
        a = mix_toward(p0, p1, tt);
        b = mix_toward(p1, p2, tt);
        c = mix_toward(p2, p3, tt);
        d = mix_toward(a, b, tt);
        e = mix_toward(b, c, tt);
        r = mix_toward(d, e, tt);
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[cbse_pkg::COORD_W-1:0];
    endfunction

    function automatic cbse_pkg::vec3_t curve_at(input logic [TBITS:0] t);
        longint          segs, len, tt, tv;
        int              i0;
        spline_point_t   p, q;
        cbse_pkg::vec3_t r;
        segs = effective_count() - 1;
        tv = longint'(t);
        if (tv > ONE_T)
            tv = ONE_T;
        len = tv * segs;
        i0 = int'(len >>> TBITS);
        tt = len & (ONE_T - 1);
        // End of curve: clamp onto the last segment at its far end
        if (i0 >= segs)
        begin
            i0 = int'(segs) - 1;
            tt = ONE_T;
        end
        p = point_table[i0];
        q = point_table[i0 + 1];
        r.x = blend_axis(p.anchor.x, p.right.x, q.left.x, q.anchor.x, tt);
        r.y = blend_axis(p.anchor.y, p.right.y, q.left.y, q.anchor.y, tt);
        r.z = blend_axis(p.anchor.z, p.right.z, q.left.z, q.anchor.z, tt);
        return r;
    endfunction

    function automatic logic signed [cbse_pkg::COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return cbse_pkg::COORD_MAX;
            1:       return cbse_pkg::COORD_MIN;
            2, 3, 4: return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic spline_point_t rand_point();
        spline_point_t p;
        p.anchor = xyz(rand_coord(), rand_coord(), rand_coord());
        p.left   = xyz(rand_coord(), rand_coord(), rand_coord());
        p.right  = xyz(rand_coord(), rand_coord(), rand_coord());
        return p;
    endfunction

    // Mostly well-formed traffic: fill any hole in the live range first, then a
    // blend of evaluations and reloads with the odd load outside the live range
    function automatic command_t random_cmd();
        command_t c;
        int       n, hole, pick;
        n = effective_count();
        hole = -1;
        for (int i = n - 1; i >= 0; i--)
            if (!loaded_mask[i])
                hole = i;
        pick = $urandom_range(0, 99);
        c = '0;
        c.pt  = rand_point();
        c.idx = cbse_pkg::INDEX_W'($urandom_range(0, NPTS - 1));
        if (hole >= 0)
        begin
            c.action = cbse_pkg::ACT_LOAD;
            c.idx    = cbse_pkg::INDEX_W'(hole);
        end
        else if (pick < 30)
        begin
            c.action = cbse_pkg::ACT_LOAD;
            if (pick >= 5)
                c.idx = cbse_pkg::INDEX_W'($urandom_range(0, n - 1));
        end
        else
        begin
            c.action = cbse_pkg::ACT_EVAL;
            case ($urandom_range(0, 9))
                0:       c.t = '0;
                1:       c.t = (TBITS+1)'(ONE_T);
                2:       c.t = (TBITS+1)'($urandom_range(32'(ONE_T) + 1, 32'h1FFFF));
                3:       c.t = (TBITS+1)'(($urandom_range(0, n - 1) << TBITS) / (n - 1));
                default: c.t = (TBITS+1)'($urandom_range(0, 32'(ONE_T)));
            endcase
        end
        return c;
    endfunction

    // Idle at random, then hold the command until it is taken and book it
    task automatic issue(input command_t c, input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start   <= 1'b0;
            action  <= 1'($urandom);
            param_t <= (TBITS+1)'($urandom);
            @(posedge clk);
        end
        start       <= 1'b1;
        action      <= c.action;
        point_index <= c.idx;
        anchor_x_in <= c.pt.anchor.x;
        anchor_y_in <= c.pt.anchor.y;
        anchor_z_in <= c.pt.anchor.z;
        left_x_in   <= c.pt.left.x;
        left_y_in   <= c.pt.left.y;
        left_z_in   <= c.pt.left.z;
        right_x_in  <= c.pt.right.x;
        right_y_in  <= c.pt.right.y;
        right_z_in  <= c.pt.right.z;
        param_t     <= c.t;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (c.action == cbse_pkg::ACT_LOAD)
        begin
            point_table[c.idx] = c.pt;
            loaded_mask[c.idx] = 1'b1;
            loads_done++;
        end
        else
        begin
            pending_curves.insert(pending_curves.size(),
                                  c.typed ? c.result : curve_at(c.t));
            evals_done++;
        end
    endtask

    task automatic read_count(input logic [cbse_pkg::COUNT_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_POINT_COUNT;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== cbse_pkg::APB_DATA_W'(want))
        begin
            $display("%0t point_count readback: expected %0d, actual %0d", $time, want, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drain the pipeline, write point_count and read it back
    task automatic write_count(input logic [cbse_pkg::COUNT_W-1:0] v);
        start <= 1'b0;
        while (pending_curves.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_POINT_COUNT;
        pwdata  <= cbse_pkg::APB_DATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        count_reg = v;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        read_count(v);
    endtask

    // Result side: every strobe must match the oldest outstanding evaluation
    always @(posedge clk)
    begin
        cbse_pkg::vec3_t want, got;
        if (rst_n && done !== 1'b0)
        begin
            got = xyz(curve_x, curve_y, curve_z);
            if (pending_curves.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %h", $time, got);
                mismatches++;
            end
            else
            begin
                want = pending_curves.pop_front();
                for (int k = 0; k < 3; k++)
                    if (want[k*cbse_pkg::COORD_W +: cbse_pkg::COORD_W]
                        !== got[k*cbse_pkg::COORD_W +: cbse_pkg::COORD_W])
                    begin
                        $display("%0t curve_%s: expected %h, actual %h", $time, axis_name[k],
                                 want[k*cbse_pkg::COORD_W +: cbse_pkg::COORD_W],
                                 got[k*cbse_pkg::COORD_W +: cbse_pkg::COORD_W]);
                        mismatches++;
                    end
            end
        end
    end

    // Watchdog: give up when nothing moves on any port for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        read_count(cbse_pkg::COUNT_RESET);

        // Directed table at the reset count of two points, one segment
        add_row(load_cmd(0, xyz(cbse_pkg::COORD_MAX, cbse_pkg::COORD_MIN, 0), xyz(1, 2, 3),
                         xyz(cbse_pkg::COORD_MIN, cbse_pkg::COORD_MAX, -1)));
        add_row(load_cmd(1, xyz(cbse_pkg::COORD_MIN, cbse_pkg::COORD_MAX, 65536),
                         xyz(cbse_pkg::COORD_MAX, cbse_pkg::COORD_MIN, -65536),
                         xyz(0, 0, 0)));
        // Start of curve gives the first anchor, the end and beyond give the last
        add_row(eval_cmd(0, 1'b1, xyz(cbse_pkg::COORD_MAX, cbse_pkg::COORD_MIN, 0)));
        add_row(eval_cmd(65536, 1'b1, xyz(cbse_pkg::COORD_MIN, cbse_pkg::COORD_MAX, 65536)));
        add_row(eval_cmd(65537, 1'b1, xyz(cbse_pkg::COORD_MIN, cbse_pkg::COORD_MAX, 65536)));
        add_row(eval_cmd(131071, 1'b1, xyz(cbse_pkg::COORD_MIN, cbse_pkg::COORD_MAX, 65536)));
        add_row(eval_cmd(32768, 1'b0, '0));
        add_row(eval_cmd(1, 1'b0, '0));
        add_row(eval_cmd(65535, 1'b0, '0));
        // Segment running from one extreme to the other
        add_row(load_cmd(0,
                         xyz(cbse_pkg::COORD_MAX, cbse_pkg::COORD_MAX, cbse_pkg::COORD_MAX),
                         xyz(cbse_pkg::COORD_MAX, cbse_pkg::COORD_MAX, cbse_pkg::COORD_MAX),
                         xyz(cbse_pkg::COORD_MAX, cbse_pkg::COORD_MAX, cbse_pkg::COORD_MAX)));
        add_row(load_cmd(1,
                         xyz(cbse_pkg::COORD_MIN, cbse_pkg::COORD_MIN, cbse_pkg::COORD_MIN),
                         xyz(cbse_pkg::COORD_MIN, cbse_pkg::COORD_MIN, cbse_pkg::COORD_MIN),
                         xyz(cbse_pkg::COORD_MIN, cbse_pkg::COORD_MIN, cbse_pkg::COORD_MIN)));
        add_row(eval_cmd(0, 1'b1,
                         xyz(cbse_pkg::COORD_MAX, cbse_pkg::COORD_MAX, cbse_pkg::COORD_MAX)));
        add_row(eval_cmd(65536, 1'b1,
                         xyz(cbse_pkg::COORD_MIN, cbse_pkg::COORD_MIN, cbse_pkg::COORD_MIN)));
        add_row(eval_cmd(32768, 1'b0, '0));
        add_row(eval_cmd(16384, 1'b0, '0));
        // Flat zero segment stays at zero everywhere
        add_row(load_cmd(0, '0, '0, '0));
        add_row(load_cmd(1, '0, '0, '0));
        add_row(eval_cmd(40000, 1'b1, xyz(0, 0, 0)));
        // Top of the table, ready for the larger counts
        add_row(load_cmd(63, xyz(-1, -1, -1), xyz(cbse_pkg::COORD_MAX, 0, cbse_pkg::COORD_MIN),
                         xyz(cbse_pkg::COORD_MIN, 0, cbse_pkg::COORD_MAX)));
        add_row(load_cmd(62, xyz(32'h1234_5678, -32'sh0000_8000, 7),
                         xyz(-5, 5, 0), xyz(1, -1, 32'h0001_0000)));
        foreach (directed[i])
            issue(directed[i], 0);

        // Random phases, each at its own point count, cycling through three idle patterns
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_count(phase_counts[p]);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                issue(random_cmd(), idle_pct_by_phase[p % 3]);
        end

        start <= 1'b0;
        while (pending_curves.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Covered %0d point loads and %0d curve evaluations over %0d point counts,",
                 loads_done, evals_done, NUM_PHASES + 1);
        $display("including out-of-range counts, end-of-curve and above-one parameters.");
        if (mismatches == 0 && pending_curves.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: cubic_bezier_spline_evaluator_unit.f
hw/rtl/cbse_pkg.sv
hw/rtl/cbse_ram.sv
hw/rtl/cbse_lerp.sv
hw/rtl/cbse_blend.sv
hw/rtl/cubic_bezier_spline_evaluator_unit.sv
test/testbench.sv
